@@ rtl/brfs_pkg.sv @@
// shared types, constants and index arithmetic for the byte ring fifo
package brfs_pkg;

  // counts and indices never exceed the largest programmable ring size
  localparam int CW        = 11;
  localparam int FW        = 10;
  localparam int RING_MAX  = 2047;
  localparam int RING_MIN  = 2;
  localparam int RING_RST  = 1024;

  typedef enum logic [2:0] {
    CMD_PUSH       = 3'd0,
    CMD_POP        = 3'd1,
    CMD_SKIP_READ  = 3'd2,
    CMD_SKIP_WRITE = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  write_data;
    logic [10:0] skip_length;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  read_data;
    logic [9:0]  used_count;
    logic [9:0]  free_count;
    logic        is_empty;
    logic        is_full;
    logic [9:0]  read_position;
    logic [9:0]  contiguous_read_length;
    logic [9:0]  write_position;
    logic [9:0]  contiguous_write_length;
  } out_t;

  // ring state seen by the status logic
  typedef struct packed {
    logic [CW-1:0] wr;
    logic [CW-1:0] rd;
    logic [CW-1:0] used;
    logic [CW-1:0] free;
    logic [CW-1:0] n;
    logic          acc;
    logic          pop_ok;
  } ring_st_t;

  // idx + len modulo n, valid while idx < n and len < n
  function automatic logic [CW-1:0] ring_adv(input logic [CW-1:0] idx,
                                             input logic [CW-1:0] len,
                                             input logic [CW-1:0] n);
    logic [CW:0] sum;
    logic [CW:0] red;
    sum = {1'b0, idx} + {1'b0, len};
    red = sum - {1'b0, n};
    if (sum >= {1'b0, n}) begin
      ring_adv = red[CW-1:0];
    end else begin
      ring_adv = sum[CW-1:0];
    end
  endfunction

endpackage

@@ rtl/byte_ring_fifo_with_skip_unit.sv @@
// top level of the byte ring fifo with skip commands
//
// usage: each input transaction carries one command (push, pop, skip read,
// skip write, clear) and yields exactly one output transaction with the
// accept flag, the popped byte and the ring status after the command.
// channels use valid/stall; a transaction completes on a clock edge with
// valid high and stall low. cfg_wr_en/cfg_wr_data program the ring size
// (clamped to 2..DEPTH, capacity one less) and reset both indices; write
// it only while no command is in flight.
// latency: the result is valid in the cycle after the command is taken.
// throughput: one command per cycle unless stalled; the byte store is a
// single-port synchronous ram, touched at most once per command, and the
// index/count update is combinational on the registered state.
// stall: while a result is held, in_stall is raised and no command is
// taken, so the ring state and the result stay frozen.
// reset: indices and used count clear, ring size returns to 1024 (or DEPTH
// if smaller); the byte store is not cleared, no clearing pass is needed.
module byte_ring_fifo_with_skip_unit #(
  parameter int DEPTH = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  brfs_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output brfs_pkg::out_t  out_data,
  input  logic            cfg_wr_en,
  input  logic [10:0]     cfg_wr_data
);
  import brfs_pkg::*;

  // ring sizes above the register range can never be reached
  localparam int MEM_DEPTH = (DEPTH > RING_MAX) ? RING_MAX : DEPTH;
  localparam int IW        = $clog2(MEM_DEPTH);

  logic          mem_we;
  logic          mem_re;
  logic [IW-1:0] mem_addr;
  logic [7:0]    mem_rdata;
  ring_st_t      st;

  // command decode, index registers and handshake
  brfs_ctrl #(
    .MEM_DEPTH (MEM_DEPTH),
    .IW        (IW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mem_we      (mem_we),
    .mem_re      (mem_re),
    .mem_addr    (mem_addr),
    .st          (st)
  );

  // byte store, read data lands together with the updated state
  brfs_ram #(
    .ENTRIES (MEM_DEPTH),
    .AW      (IW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (in_data.write_data),
    .rdata (mem_rdata)
  );

  // result fields derived from the registered state
  brfs_status u_status (
    .st      (st),
    .rd_byte (mem_rdata),
    .res     (out_data)
  );

endmodule

@@ rtl/brfs_ram.sv @@
// byte store: one write or read port, registered read data
module brfs_ram #(
  parameter int ENTRIES = 1024,
  parameter int AW      = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [0:ENTRIES-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ rtl/brfs_ctrl.sv @@
// command sequencer: index and count registers, memory access, handshake
module brfs_ctrl #(
  parameter int MEM_DEPTH = 1024,
  parameter int IW        = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  brfs_pkg::in_t     in_data,
  output logic              out_valid,
  input  logic              out_stall,
  input  logic              cfg_wr_en,
  input  logic [10:0]       cfg_wr_data,
  output logic              mem_we,
  output logic              mem_re,
  output logic [IW-1:0]     mem_addr,
  output brfs_pkg::ring_st_t st
);
  import brfs_pkg::*;

  localparam int NRESET = (RING_RST > MEM_DEPTH) ? MEM_DEPTH : RING_RST;

  logic [IW-1:0] wr, wr_next;
  logic [IW-1:0] rd, rd_next;
  logic [CW-1:0] used, used_next;
  logic [CW-1:0] free, free_next;
  logic [CW-1:0] n, n_next;
  logic          acc, acc_next;
  logic          pop_ok, pop_ok_next;
  logic          out_valid_next;
  logic          accept;
  logic [CW-1:0] len;
  logic [CW-1:0] rlen;
  logic [CW-1:0] wlen;
  logic          push_ok;
  logic          pop_go;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign len      = in_data.skip_length;
  assign rlen     = (len > used) ? used : len;
  assign wlen     = (len > free) ? free : len;
  assign push_ok  = (free != '0);
  assign pop_go   = (used != '0);

  assign mem_we   = accept && (in_data.command == CMD_PUSH) && push_ok;
  assign mem_re   = accept && (in_data.command == CMD_POP) && pop_go;
  assign mem_addr = mem_we ? wr : rd;

  always_comb begin
    wr_next        = wr;
    rd_next        = rd;
    used_next      = used;
    free_next      = free;
    n_next         = n;
    acc_next       = acc;
    pop_ok_next    = pop_ok;
    out_valid_next = out_valid && out_stall;
    if (cfg_wr_en) begin
      // clamp to the legal ring size, then restart both indices
      if (cfg_wr_data < CW'(RING_MIN)) begin
        n_next = CW'(RING_MIN);
      end else if (cfg_wr_data > CW'(MEM_DEPTH)) begin
        n_next = CW'(MEM_DEPTH);
      end else begin
        n_next = cfg_wr_data;
      end
      wr_next   = '0;
      rd_next   = '0;
      used_next = '0;
      free_next = n_next - CW'(1);
    end else if (accept) begin
      out_valid_next = 1'b1;
      acc_next       = 1'b0;
      pop_ok_next    = 1'b0;
      case (in_data.command)
        CMD_PUSH: begin
          if (push_ok) begin
            wr_next   = IW'(ring_adv(CW'(wr), CW'(1), n));
            used_next = used + CW'(1);
            free_next = free - CW'(1);
            acc_next  = 1'b1;
          end
        end
        CMD_POP: begin
          if (pop_go) begin
            rd_next     = IW'(ring_adv(CW'(rd), CW'(1), n));
            used_next   = used - CW'(1);
            free_next   = free + CW'(1);
            acc_next    = 1'b1;
            pop_ok_next = 1'b1;
          end
        end
        CMD_SKIP_READ: begin
          rd_next   = IW'(ring_adv(CW'(rd), rlen, n));
          used_next = used - rlen;
          free_next = free + rlen;
          acc_next  = 1'b1;
        end
        CMD_SKIP_WRITE: begin
          wr_next   = IW'(ring_adv(CW'(wr), wlen, n));
          used_next = used + wlen;
          free_next = free - wlen;
          acc_next  = 1'b1;
        end
        CMD_CLEAR: begin
          wr_next   = '0;
          rd_next   = '0;
          used_next = '0;
          free_next = n - CW'(1);
          acc_next  = 1'b1;
        end
        default: begin
          acc_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr        <= '0;
      rd        <= '0;
      used      <= '0;
      free      <= CW'(NRESET - 1);
      n         <= CW'(NRESET);
      acc       <= 1'b0;
      pop_ok    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      wr        <= wr_next;
      rd        <= rd_next;
      used      <= used_next;
      free      <= free_next;
      n         <= n_next;
      acc       <= acc_next;
      pop_ok    <= pop_ok_next;
      out_valid <= out_valid_next;
    end
  end

  assign st = '{wr: CW'(wr), rd: CW'(rd), used: used, free: free, n: n,
                acc: acc, pop_ok: pop_ok};

`ifndef NO_ASSERTIONS
  // occupancy bookkeeping stays consistent with the ring size
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, used} + {1'b0, free} + (CW+1)'(1)) == {1'b0, n})
    else $error("used and free counts out of step with ring size");

  // indices stay inside the ring
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (CW'(wr) < n) && (CW'(rd) < n))
    else $error("ring index beyond ring size");

  // a held result freezes the ring state
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && !cfg_wr_en |=> $stable(wr) && $stable(rd) && $stable(acc))
    else $error("ring state moved under a stalled result");

  // a successful pop is always reported as accepted
  a_pop_acc: assert property (@(posedge clk) disable iff (rst)
    pop_ok |-> acc)
    else $error("pop data flagged without acceptance");

  // memory is never read and written in the same cycle
  a_mem_port: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("byte store read and write collide");
`endif

endmodule

@@ rtl/brfs_status.sv @@
// status fields of one result from the ring state and the popped byte
module brfs_status (
  input  brfs_pkg::ring_st_t st,
  input  logic [7:0]         rd_byte,
  output brfs_pkg::out_t     res
);
  import brfs_pkg::*;

  logic          empty;
  logic          full;
  logic [CW-1:0] crl;
  logic [CW-1:0] cwl;
  logic [CW-1:0] tail_w;

  assign empty  = (st.used == '0);
  assign full   = (st.free == '0);
  assign tail_w = st.n - st.wr;

  always_comb begin
    if (empty) begin
      crl = '0;
    end else if (st.wr > st.rd) begin
      crl = st.used;
    end else begin
      crl = st.n - st.rd;
    end
    // below the read index the gap is exactly the free count
    if (full) begin
      cwl = '0;
    end else if (st.wr >= st.rd) begin
      cwl = (tail_w > st.free) ? st.free : tail_w;
    end else begin
      cwl = st.free;
    end
  end

  always_comb begin
    res.accepted                = st.acc;
    res.read_data               = st.pop_ok ? rd_byte : 8'd0;
    res.used_count              = FW'(st.used);
    res.free_count              = FW'(st.free);
    res.is_empty                = empty;
    res.is_full                 = full;
    res.read_position           = FW'(st.rd);
    res.contiguous_read_length  = FW'(crl);
    res.write_position          = FW'(st.wr);
    res.contiguous_write_length = FW'(cwl);
  end

endmodule
